// ===== sv/lgen_pkg.sv =====
// shared types, constants and the b3/s23 rule for the life row stencil
// no dependencies
package lgen_pkg;

    localparam int ROW_BITS      = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd64;
    localparam logic [3:0]            BORN_COUNT    = 4'd3;
    localparam logic [3:0]            SURVIVE_COUNT = 4'd2;

    // bits one cell shows to its neighbors
    typedef struct packed {
        logic above;
        logic held;
        logic cur;
    } nbr_t;

    typedef struct packed {
        logic                frame_end;
        logic [ROW_BITS-1:0] next_cells;
    } res_t;

    // up, mid, down: bit 0 left column, bit 1 own column, bit 2 right column
    function automatic logic life_rule(input logic [2:0] up, input logic [2:0] mid,
                                       input logic [2:0] down);
        logic [3:0] n;
        n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(down[0]) + 4'(down[1])
          + 4'(down[2]) + 4'(mid[0]) + 4'(mid[2]);
        return (n == BORN_COUNT) || ((n == SURVIVE_COUNT) && mid[1]);
    endfunction

endpackage

// ===== sv/lgen_cell.sv =====
// one column of the stencil: holds the column's bit of the two previous rows
// depends on lgen_pkg
module lgen_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          col_en,
    input  logic          take,
    input  logic          last,
    input  logic          cur_bit,
    input  lgen_pkg::nbr_t left,
    input  lgen_pkg::nbr_t right,
    output lgen_pkg::nbr_t self,
    output logic          mid_next,
    output logic          last_next
);
    import lgen_pkg::*;

    logic above_reg, above_next;
    logic held_reg, held_next;

    assign self.above = above_reg & col_en;
    assign self.held  = held_reg & col_en;
    assign self.cur   = cur_bit & col_en;

    assign mid_next  = col_en & life_rule({right.above, self.above, left.above},
                                          {right.held, self.held, left.held},
                                          {right.cur, self.cur, left.cur});
    assign last_next = col_en & life_rule({right.held, self.held, left.held},
                                          {right.cur, self.cur, left.cur},
                                          3'b000);

    always_comb
    begin
        above_next = above_reg;
        held_next  = held_reg;
        if (take)
        begin
            if (last)
            begin
                above_next = 1'b0;
                held_next  = 1'b0;
            end
            else
            begin
                above_next = held_reg;
                held_next  = self.cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            held_reg  <= 1'b0;
        end
        else
        begin
            above_reg <= above_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== sv/lgen_out_fifo.sv =====
// result queue, takes up to two results per cycle and gives one
// depends on lgen_pkg
module lgen_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_a,
    input  logic          push_b,
    input  lgen_pkg::res_t data_a,
    input  lgen_pkg::res_t data_b,
    input  logic          pop,
    output logic          not_empty,
    output logic          room_two,
    output lgen_pkg::res_t head
);
    import lgen_pkg::*;

    res_t                     mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_b;

    assign not_empty = (count_reg != '0);
    assign room_two  = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign wr_ptr_b  = wr_ptr_reg + FIFO_PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push_a) + FIFO_PTR_BITS'(push_b);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(push_a) + FIFO_CNT_BITS'(push_b)
                    - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            mem_reg[wr_ptr_reg] <= data_a;
        if (push_b)
            mem_reg[wr_ptr_b] <= data_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/life_generation_row_stencil_top.sv =====
// life b3/s23 row stencil: chain of column cells and a four-entry result queue
// results are registered in the result queue and leave it from its head in order
// throughput: one row per cycle; input ready while the queue holds two or fewer
// a last row with a held row queues two results in one cycle
// reset (async, active low) clears held rows, queue and sets row_width to 64
module life_generation_row_stencil_top #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // row_width
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // row_cells[63:0]
    input  logic        s_tlast,       // last_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // next_cells[63:0]
    output logic        m_tlast        // frame_end
);
    import lgen_pkg::*;

    logic [WIDTH_BITS-1:0] row_width_reg, row_width_next;
    logic                  pending_reg, pending_next;
    logic                  accept;
    logic [ROW_BITS-1:0]   mid_row;
    logic [ROW_BITS-1:0]   last_res;
    nbr_t                  nbr_bus [MAX_COLUMNS+2];
    res_t                  data_a, data_b, head;
    logic                  push_a, push_b, pop, room_two;

    assign accept = s_tvalid & s_tready;
    assign nbr_bus[0]             = '0;
    assign nbr_bus[MAX_COLUMNS+1] = '0;

    for (genvar k = 0; k < ROW_BITS; k++)
    begin : g_col
        if (k < MAX_COLUMNS)
        begin : g_cell
            lgen_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .col_en    (row_width_reg > WIDTH_BITS'(k)),
                .take      (accept),
                .last      (s_tlast),
                .cur_bit   (s_tdata[k]),
                .left      (nbr_bus[k]),
                .right     (nbr_bus[k+2]),
                .self      (nbr_bus[k+1]),
                .mid_next  (mid_row[k]),
                .last_next (last_res[k])
            );
        end
        else
        begin : g_dead
            assign mid_row[k]  = 1'b0;
            assign last_res[k] = 1'b0;
        end
    end

    assign push_a = accept & (pending_reg | s_tlast);
    assign push_b = accept & pending_reg & s_tlast;
    assign pop    = m_tvalid & m_tready;

    always_comb
    begin
        data_a.next_cells = pending_reg ? mid_row : last_res;
        data_a.frame_end  = ~pending_reg;
        data_b.next_cells = last_res;
        data_b.frame_end  = 1'b1;
        pending_next      = accept ? ~s_tlast : pending_reg;
        row_width_next    = cfg_wr_en ? cfg_wr_data : row_width_reg;
    end

    lgen_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .data_a    (data_a),
        .data_b    (data_b),
        .pop       (pop),
        .not_empty (m_tvalid),
        .room_two  (room_two),
        .head      (head)
    );

    assign s_tready = room_two;
    assign m_tdata  = head.next_cells;
    assign m_tlast  = head.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WIDTH_RESET;
            pending_reg   <= 1'b0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

// ===== sv/lgen_checker.sv =====
// port-level checks for the life row stencil top
// bound to life_generation_row_stencil_top, no package use
module lgen_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [6:0]  cfg_wr_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // input stalls only when results are queued
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a last row always yields a result
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after last row");

    // no result appears without an input transfer
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result without input transfer");

endmodule

bind life_generation_row_stencil_top lgen_checker u_lgen_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for life_generation_row_stencil_top: streams life grids one row per transfer
// and checks every next-generation row against its own b3/s23 row predictor
// depends on lgen_pkg and life_generation_row_stencil_top
module tb;
    import lgen_pkg::*;

    localparam int HOLD_CYCLES = 60;

    class life_rows_sb;
        logic [WIDTH_BITS-1:0] row_width;
        logic [ROW_BITS-1:0]   row_above;
        logic [ROW_BITS-1:0]   row_held;
        bit                    row_pending;
        res_t                  expected_rows[$];
        int                    errors;

        function new();
            row_width   = WIDTH_RESET;
            row_above   = '0;
            row_held    = '0;
            row_pending = 0;
            errors      = 0;
        endfunction

        function logic [ROW_BITS-1:0] col_mask();
            int w;
            w = (row_width > 64) ? 64 : row_width;
            if (w >= 64)
                return '1;
            return (64'd1 << w) - 64'd1;
        endfunction

        function logic [ROW_BITS-1:0] next_gen(logic [ROW_BITS-1:0] up,
                                               logic [ROW_BITS-1:0] mid,
                                               logic [ROW_BITS-1:0] down,
                                               logic [ROW_BITS-1:0] mask);
            logic [ROW_BITS-1:0] res;
            int                  n;
            int                  c;
            res  = '0;
            up   = up & mask;
            mid  = mid & mask;
            down = down & mask;
            for (int k = 0; k < ROW_BITS; k++)
            begin
                n = 0;
                for (int d = -1; d <= 1; d++)
                begin
                    c = k + d;
                    if (c >= 0 && c < ROW_BITS)
                    begin
                        n += up[c] + down[c];
                        if (d != 0)
                            n += mid[c];
                    end
                end
                if (n == 3 || (n == 2 && mid[k]))
                    res[k] = 1'b1;
            end
            return res & mask;
        endfunction

        function void note_row(logic [ROW_BITS-1:0] cells, logic last);
            logic [ROW_BITS-1:0] mask;
            logic [ROW_BITS-1:0] cur;
            res_t                r;
            mask = col_mask();
            cur  = cells & mask;
            if (row_pending)
            begin
                r.next_cells = next_gen(row_above, row_held, cur, mask);
                r.frame_end  = 1'b0;
                expected_rows.push_back(r);
            end
            if (last)
            begin
                r.next_cells = next_gen(row_pending ? row_held : '0, cur, '0, mask);
                r.frame_end  = 1'b1;
                expected_rows.push_back(r);
                row_above   = '0;
                row_held    = '0;
                row_pending = 0;
            end
            else
            begin
                row_above   = row_pending ? row_held : '0;
                row_held    = cur;
                row_pending = 1;
            end
        endfunction

        function void check_row(logic [ROW_BITS-1:0] cells, logic fe);
            res_t r;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected result transfer: next_cells %h frame_end %b", cells, fe);
                errors++;
                return;
            end
            r = expected_rows.pop_front();
            if (cells !== r.next_cells)
            begin
                $error("next_cells: expected %h, got %h", r.next_cells, cells);
                errors++;
            end
            if (fe !== r.frame_end)
            begin
                $error("frame_end: expected %b, got %b", r.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    life_rows_sb sb = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    life_generation_row_stencil_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver side, with an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_row(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_row(s_tdata, s_tlast);
        end
    end

    task automatic send_row(logic [63:0] cells, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_width(logic [6:0] w);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        sb.row_width = w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] random_row(logic [63:0] prev);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: return a;
            3, 4:    return a & b & c;
            5:       return a | b;
            6:       return '0;
            7:       return '1;
            8:       return prev ^ (a & b & c);
            default: return {prev[62:0], prev[63]};
        endcase
    endfunction

    task automatic run_frames(int n_items);
        int          sent;
        int          height;
        logic [63:0] row;
        sent = 0;
        row  = '0;
        while (sent < n_items)
        begin
            case ($urandom_range(19))
                0:       height = 1;
                1, 2, 3: height = $urandom_range(7, 20);
                default: height = $urandom_range(2, 6);
            endcase
            for (int r = 0; r < height; r++)
            begin
                row = random_row(row);
                send_row(row, r == height - 1);
            end
            sent += height;
        end
    endtask

    initial
    begin
        logic [6:0] widths[12];
        widths = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd127, 7'd64,
                   7'd65, 7'd7, 7'd33, 7'd63, 7'd100, 7'd64};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-row frames
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        // blinker, block, a glider against the high edge and an alternating-bit frame
        send_row(64'h8, 1'b0);
        send_row(64'h8, 1'b0);
        send_row(64'h8, 1'b1);
        send_row(64'h3, 1'b0);
        send_row(64'h3, 1'b1);
        send_row(64'h4000_0000_0000_0000, 1'b0);
        send_row(64'h2000_0000_0000_0000, 1'b0);
        send_row(64'hE000_0000_0000_0000, 1'b0);
        send_row('0, 1'b1);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row('1, 1'b1);
        // narrow grid, unused columns set
        set_width(7'd5);
        send_row('1, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFE0, 1'b1);
        // zero width
        set_width(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // width above the column count
        set_width(7'd127);
        send_row('1, 1'b0);
        send_row(64'h5, 1'b1);

        for (int ph = 0; ph < 12; ph++)
        begin
            set_width((ph == 11) ? 7'($urandom_range(1, 64)) : widths[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (ph == 4 || ph == 8)
                hold_req++;
            run_frames(145);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.expected_rows.size() != 0)
        begin
            $error("%0d expected result rows never arrived", sb.expected_rows.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
